/* src/hdpu_pkg.sv */
// ----------------------------------------------------------------------------
// hdpu_pkg: shared constants for the heading/distance position update
// Field widths of the stream items and the fixed-point constants used to
// build the quarter-wave sine table.
// ----------------------------------------------------------------------------
package hdpu_pkg;

  // fixed field widths of the items
  localparam int HEADING_W = 12;
  localparam int FACING_W  = 12;
  localparam int DIST_W    = 16;

  // pi/2 in Q2.30 and the Q30 rounding constant
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ROUND   = 64'd1 << 29;

  // number of Taylor terms after the first
  localparam int TAYLOR_TERMS = 12;

  // divisor of each Taylor term, (2n)(2n+1) for n = 1..TAYLOR_TERMS
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

endpackage

/* src/hdpu_trig_rom.sv */
// ----------------------------------------------------------------------------
// hdpu_trig_rom: quarter-wave sine table
// Holds sin(r * pi/2 / QUADRANT_STEPS) for r = 0..QUADRANT_STEPS in unsigned
// Q1.TRIG_FRAC_BITS. Two read ports with registered read data.
// ----------------------------------------------------------------------------
module hdpu_trig_rom #(
  parameter int QUADRANT_STEPS = 1024,
  parameter int TRIG_FRAC_BITS = 16,
  localparam int ROM_DEPTH     = QUADRANT_STEPS + 1,
  localparam int ADDR_W        = $clog2(ROM_DEPTH),
  localparam int COEF_W        = TRIG_FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr_a,
  input  logic [ADDR_W-1:0] addr_b,
  output logic [COEF_W-1:0] data_a_r,
  output logic [COEF_W-1:0] data_b_r
);

  import hdpu_pkg::*;

  typedef logic [COEF_W-1:0] coef_tab_t [ROM_DEPTH];

  localparam longint unsigned QS_DIV  = 64'(QUADRANT_STEPS);
  localparam longint unsigned QS_HALF = 64'(QUADRANT_STEPS / 2);

  // taylor series in Q2.30, rounded to the table format and capped at one
  function automatic logic [COEF_W-1:0] quarter_sin(input int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned res;
    x = (64'(r) * HALF_PI_Q30 + QS_HALF) / QS_DIV;
    x2 = (x * x + Q30_ROUND) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2 + Q30_ROUND) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    res = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    if (res > (64'd1 << TRIG_FRAC_BITS)) begin
      res = 64'd1 << TRIG_FRAC_BITS;
    end
    return COEF_W'(res);
  endfunction

  function automatic coef_tab_t build_table();
    coef_tab_t tab;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      tab[i] = quarter_sin(i);
    end
    return tab;
  endfunction

  localparam coef_tab_t SIN_TABLE = build_table();

  // registered reads on both ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= SIN_TABLE[addr_a];
      data_b_r <= SIN_TABLE[addr_b];
    end
  end

endmodule

/* src/heading_distance_position_update.sv */
// ----------------------------------------------------------------------------
// heading_distance_position_update: dead-reckoning position step
// Moves a position a signed distance along a binary-angle heading, with
// saturating coordinates.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one item per move: position, heading (4*QUADRANT_STEPS steps per
//           turn, 0 along +Y, clockwise), facing and signed distance.
//   out_* : one item per input item, in order: new position, facing passed
//           through, and a flag set when either coordinate was clamped.
// Timing
//   Four register stages: input register, sine table read, scaling
//   multipliers, coordinate add and clamp into the output register.
//   out_tvalid rises once the item has passed the table read, scaling and output registers.
//   One item per cycle sustained while out_tready is high; the table has two read ports so sine
//   and cosine come out together.
// Reset
//   rst_n clears all stage valid flags; the table is constant and needs
//   no fill, so items are taken from the first cycle after reset.
// Back-pressure
//   Each stage holds while the stage after it is full and stalled, and
//   empty stages keep filling, so up to four items sit in the pipe while
//   out_tready is low before in_tready drops.
// ----------------------------------------------------------------------------
module heading_distance_position_update #(
  parameter int QUADRANT_STEPS = 1024,
  parameter int TRIG_FRAC_BITS = 16,
  parameter int COORD_WIDTH    = 24,
  localparam int IN_BITS       = 2 * COORD_WIDTH + 40,
  localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS      = 2 * COORD_WIDTH + 13,
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, heading, robot_facing, move_distance
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_x, next_y, next_facing, saturated
  output logic [OUT_DATA_W-1:0] out_tdata
);

  import hdpu_pkg::*;

  localparam int ROM_DEPTH   = QUADRANT_STEPS + 1;
  localparam int ADDR_W      = $clog2(ROM_DEPTH);
  localparam int COEF_W      = TRIG_FRAC_BITS + 1;
  localparam int MAG_W       = DIST_W + 1;
  localparam int PROD_W      = MAG_W + COEF_W;
  localparam int SUM_W       = COORD_WIDTH + 2;

  // field offsets in in_tdata
  localparam int POS_Y_LSB   = COORD_WIDTH;
  localparam int HEAD_LSB    = 2 * COORD_WIDTH;
  localparam int FACE_LSB    = HEAD_LSB + HEADING_W;
  localparam int DIST_LSB    = FACE_LSB + FACING_W;

  // heading split by reciprocal multiplication
  localparam int QS_FLOOR    = $clog2(QUADRANT_STEPS + 1) - 1;
  localparam int QUO_W       = HEADING_W - QS_FLOOR + 2;
  localparam int RECIP_SHIFT = HEADING_W + QS_FLOOR + 2;
  localparam int RECIP_W     = RECIP_SHIFT - QS_FLOOR + 2;
  localparam int QPROD_W     = HEADING_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(QUADRANT_STEPS) - 64'd1) / 64'(QUADRANT_STEPS);
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_FULL);

  // coordinate bounds
  localparam logic signed [SUM_W-1:0] COORD_MAX =
    SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

  // quadrant of the heading, named by where the movement points
  typedef enum logic [1:0] {
    QUAD_NORTH = 2'd0,
    QUAD_EAST  = 2'd1,
    QUAD_SOUTH = 2'd2,
    QUAD_WEST  = 2'd3
  } quad_t;

  // stage enables
  logic en1, en2, en3, en_out;

  // stage 1: input register
  logic                          s1_valid_r;
  logic signed [COORD_WIDTH-1:0] s1_pos_x_r;
  logic signed [COORD_WIDTH-1:0] s1_pos_y_r;
  logic [HEADING_W-1:0]          s1_heading_r;
  logic [FACING_W-1:0]           s1_facing_r;
  logic signed [DIST_W-1:0]      s1_dist_r;

  // stage 2: table read
  logic                          s2_valid_r;
  logic signed [COORD_WIDTH-1:0] s2_pos_x_r;
  logic signed [COORD_WIDTH-1:0] s2_pos_y_r;
  quad_t                         s2_quad_r;
  logic [FACING_W-1:0]           s2_facing_r;
  logic signed [DIST_W-1:0]      s2_dist_r;
  logic [COEF_W-1:0]             sin_r;
  logic [COEF_W-1:0]             cos_r;

  // stage 3: scaled deltas
  logic                          s3_valid_r;
  logic signed [COORD_WIDTH-1:0] s3_pos_x_r;
  logic signed [COORD_WIDTH-1:0] s3_pos_y_r;
  logic [FACING_W-1:0]           s3_facing_r;
  logic [MAG_W-1:0]              s3_x_mag_r;
  logic [MAG_W-1:0]              s3_y_mag_r;
  logic                          s3_neg_x_r;
  logic                          s3_neg_y_r;

  // output register
  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] out_x_r;
  logic signed [COORD_WIDTH-1:0] out_y_r;
  logic [FACING_W-1:0]           out_facing_r;
  logic                          out_sat_r;

  // a stage loads when empty or when the next one loads
  assign en_out    = !out_valid_r || out_tready;
  assign en3       = !s3_valid_r || en_out;
  assign en2       = !s2_valid_r || en3;
  assign en1       = !s1_valid_r || en2;
  assign in_tready = en1;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_tvalid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pos_x_r   <= in_tdata[COORD_WIDTH-1:0];
      s1_pos_y_r   <= in_tdata[POS_Y_LSB +: COORD_WIDTH];
      s1_heading_r <= in_tdata[HEAD_LSB +: HEADING_W];
      s1_facing_r  <= in_tdata[FACE_LSB +: FACING_W];
      s1_dist_r    <= in_tdata[DIST_LSB +: DIST_W];
    end
  end

  // quadrant and offset within it
  logic [QPROD_W-1:0]           recip_prod;
  logic [QUO_W-1:0]             quo;
  logic [HEADING_W+QUO_W-1:0]   quo_back;
  logic [HEADING_W-1:0]         rem;
  logic [ADDR_W-1:0]            addr_sin;
  logic [ADDR_W-1:0]            addr_cos;

  always_comb begin
    recip_prod = QPROD_W'(s1_heading_r) * QPROD_W'(RECIP_MUL);
    quo        = QUO_W'(recip_prod >> RECIP_SHIFT);
    quo_back   = (HEADING_W + QUO_W)'(quo) * (HEADING_W + QUO_W)'(QUADRANT_STEPS);
    rem        = s1_heading_r - HEADING_W'(quo_back);
    addr_sin   = ADDR_W'(rem);
    addr_cos   = ADDR_W'(QUADRANT_STEPS) - addr_sin;
  end

  hdpu_trig_rom #(
    .QUADRANT_STEPS (QUADRANT_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_rom (
    .clk      (clk),
    .rd_en    (en2),
    .addr_a   (addr_sin),
    .addr_b   (addr_cos),
    .data_a_r (sin_r),
    .data_b_r (cos_r)
  );

  // carry the rest of the item alongside the table read
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_pos_x_r  <= s1_pos_x_r;
      s2_pos_y_r  <= s1_pos_y_r;
      s2_quad_r   <= quad_t'(quo[1:0]);
      s2_facing_r <= s1_facing_r;
      s2_dist_r   <= s1_dist_r;
    end
  end

  // pick coefficients and signs per quadrant, then scale the distance
  logic signed [MAG_W-1:0] dist_ext;
  logic [MAG_W-1:0]        dist_mag;
  logic                    dist_neg;
  logic [COEF_W-1:0]       coef_x;
  logic [COEF_W-1:0]       coef_y;
  logic                    quad_neg_x;
  logic                    quad_neg_y;
  logic [PROD_W-1:0]       prod_x;
  logic [PROD_W-1:0]       prod_y;

  always_comb begin
    dist_ext = MAG_W'(s2_dist_r);
    dist_neg = s2_dist_r[DIST_W-1];
    dist_mag = dist_neg ? MAG_W'(-dist_ext) : MAG_W'(dist_ext);
    case (s2_quad_r)
      QUAD_NORTH: begin
        coef_x = sin_r; coef_y = cos_r; quad_neg_x = 1'b0; quad_neg_y = 1'b0;
      end
      QUAD_EAST: begin
        coef_x = cos_r; coef_y = sin_r; quad_neg_x = 1'b0; quad_neg_y = 1'b1;
      end
      QUAD_SOUTH: begin
        coef_x = sin_r; coef_y = cos_r; quad_neg_x = 1'b1; quad_neg_y = 1'b1;
      end
      QUAD_WEST: begin
        coef_x = cos_r; coef_y = sin_r; quad_neg_x = 1'b1; quad_neg_y = 1'b0;
      end
      default: begin
        coef_x = sin_r; coef_y = cos_r; quad_neg_x = 1'b0; quad_neg_y = 1'b0;
      end
    endcase
    prod_x = PROD_W'(dist_mag) * PROD_W'(coef_x);
    prod_y = PROD_W'(dist_mag) * PROD_W'(coef_y);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pos_x_r  <= s2_pos_x_r;
      s3_pos_y_r  <= s2_pos_y_r;
      s3_facing_r <= s2_facing_r;
      s3_x_mag_r  <= prod_x[TRIG_FRAC_BITS +: MAG_W];
      s3_y_mag_r  <= prod_y[TRIG_FRAC_BITS +: MAG_W];
      s3_neg_x_r  <= quad_neg_x ^ dist_neg;
      s3_neg_y_r  <= quad_neg_y ^ dist_neg;
    end
  end

  // apply deltas and clamp to the coordinate range
  logic signed [SUM_W-1:0] delta_x;
  logic signed [SUM_W-1:0] delta_y;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [COORD_WIDTH-1:0] next_x_nxt;
  logic signed [COORD_WIDTH-1:0] next_y_nxt;
  logic sat_x;
  logic sat_y;

  always_comb begin
    delta_x = $signed(SUM_W'(s3_x_mag_r));
    delta_y = $signed(SUM_W'(s3_y_mag_r));
    if (s3_neg_x_r) begin
      delta_x = -delta_x;
    end
    if (s3_neg_y_r) begin
      delta_y = -delta_y;
    end
    sum_x = SUM_W'(s3_pos_x_r) + delta_x;
    sum_y = SUM_W'(s3_pos_y_r) + delta_y;

    sat_x = 1'b1;
    if (sum_x > COORD_MAX) begin
      next_x_nxt = COORD_WIDTH'(COORD_MAX);
    end else if (sum_x < COORD_MIN) begin
      next_x_nxt = COORD_WIDTH'(COORD_MIN);
    end else begin
      next_x_nxt = COORD_WIDTH'(sum_x);
      sat_x      = 1'b0;
    end

    sat_y = 1'b1;
    if (sum_y > COORD_MAX) begin
      next_y_nxt = COORD_WIDTH'(COORD_MAX);
    end else if (sum_y < COORD_MIN) begin
      next_y_nxt = COORD_WIDTH'(COORD_MIN);
    end else begin
      next_y_nxt = COORD_WIDTH'(sum_y);
      sat_y      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_x_r      <= next_x_nxt;
      out_y_r      <= next_y_nxt;
      out_facing_r <= s3_facing_r;
      out_sat_r    <= sat_x | sat_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_sat_r, out_facing_r,
                       out_y_r, out_x_r};

  // offset inside the quadrant always addresses the table
  a_rem_in_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (int'(rem) < QUADRANT_STEPS))
    else $error("heading offset outside quadrant");

  // a clamped result sits on a bound
  a_sat_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_x_r == COORD_WIDTH'(COORD_MAX) || out_x_r == COORD_WIDTH'(COORD_MIN) ||
       out_y_r == COORD_WIDTH'(COORD_MAX) || out_y_r == COORD_WIDTH'(COORD_MIN)))
    else $error("saturated flag without clamped coordinate");

  // a full, stalled pipe takes no new item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && s1_valid_r && s2_valid_r && s3_valid_r)
      |-> !in_tready)
    else $error("item accepted into full stalled pipeline");

  // a stalled output register keeps its head result
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_x_r) &&
      $stable(out_y_r) && $stable(out_sat_r)))
    else $error("stalled result changed");

endmodule
